/* rtl/running_mean_filter_unit_defines.svh */
// assertion macros shared by the running mean filter rtl
`ifndef RUNNING_MEAN_FILTER_UNIT_DEFINES_SVH
`define RUNNING_MEAN_FILTER_UNIT_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define RMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define RMF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/rmf_pkg.sv */
// types and constants shared by the running mean filter modules
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned AVG_W    = 20;
  localparam int unsigned FILL_W   = 4;
  localparam int unsigned FRAC_W   = 8;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } rmf_in_t;

  typedef struct packed {
    logic [AVG_W-1:0]  average_q8;
    logic [FILL_W-1:0] fill_count;
  } rmf_out_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } rmf_alu_op_e;

endpackage

`default_nettype wire

/* rtl/rmf_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rmf_ram #(
  parameter int unsigned DATA_W = 12,
  parameter int unsigned DEPTH  = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/rmf_alu.sv */
// shared add / subtract unit with borrow out
`timescale 1ns / 1ps
`default_nettype none

module rmf_alu #(
  parameter int unsigned WIDTH = 16
) (
  input  rmf_pkg::rmf_alu_op_e op_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic [WIDTH-1:0]     y_o,
  output logic                 borrow_o
);

  logic [WIDTH:0] res;

  always_comb begin
    unique case (op_i)
      rmf_pkg::ALU_ADD: res = {1'b0, a_i} + {1'b0, b_i};
      rmf_pkg::ALU_SUB: res = {1'b0, a_i} - {1'b0, b_i};
      default:          res = '0;
    endcase
  end

  assign y_o      = res[WIDTH-1:0];
  // only meaningful for a subtract
  assign borrow_o = (op_i == rmf_pkg::ALU_SUB) && res[WIDTH];

endmodule

`default_nettype wire

/* rtl/running_mean_filter_unit.sv */
// running mean filter top level: sequencer, history ram and shared add/subtract unit
`timescale 1ns / 1ps
`default_nettype none
`include "running_mean_filter_unit_defines.svh"

// Moving average over the last WINDOW 12-bit samples. A filter item (action 0)
// swaps the oldest history entry for the new sample in the running sum; a prime
// item (action 1) writes the value into every entry. Each item returns the mean
// with 8 fraction bits (truncated) and the number of samples in the window.
// The running sum and the divide run through one shared add/subtract unit. The
// restoring divide by the fill count produces one quotient bit per cycle over
// SUM_W + 8 bits, where SUM_W = clog2(WINDOW*4095 + 1); priming writes every
// history entry in turn through the single ram write port.
// Input stall is high while an item is in progress; a finished result sits in
// an output register, so the next item is taken while it waits.
module running_mean_filter_unit #(
  parameter int unsigned WINDOW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rmf_pkg::rmf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rmf_pkg::rmf_out_t out_data_o
);

  localparam int unsigned SampleW = rmf_pkg::SAMPLE_W;
  localparam int unsigned FracW   = rmf_pkg::FRAC_W;
  localparam int unsigned AvgW    = rmf_pkg::AVG_W;
  localparam int unsigned FillW   = rmf_pkg::FILL_W;
  localparam int unsigned SumMax  = WINDOW * ((1 << SampleW) - 1);
  localparam int unsigned SumW    = $clog2(SumMax + 1);
  localparam int unsigned CntW    = $clog2(WINDOW + 1);
  localparam int unsigned IdxW    = $clog2(WINDOW);
  localparam int unsigned QuoW    = SumW + FracW;
  localparam int unsigned StepW   = $clog2(QuoW);

  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(WINDOW - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(WINDOW);
  localparam logic [StepW-1:0] LastStep = StepW'(QuoW - 1);
  localparam logic [SumW-1:0]  SumLimit = SumW'(SumMax);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SUB   = 6'b000010,
    ST_ADD   = 6'b000100,
    ST_PRIME = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } rmf_state_e;

  rmf_state_e          state_q, state_d;
  logic [SampleW-1:0]  sample_q, sample_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [WINDOW-1:0]   valid_q, valid_d;
  logic [QuoW-1:0]     quo_q, quo_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                out_valid_q, out_valid_d;
  rmf_pkg::rmf_out_t   out_q, out_d;

  logic                 ram_we;
  logic [SampleW-1:0]   ram_rdata;
  logic [SampleW-1:0]   old_val;
  logic [CntW:0]        trial;
  logic                 out_free;
  rmf_pkg::rmf_alu_op_e alu_op;
  logic [SumW-1:0]      alu_a, alu_b, alu_y;
  logic                 alu_borrow;

  rmf_ram #(
    .DATA_W (SampleW),
    .DEPTH  (WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (sample_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  rmf_alu #(
    .WIDTH (SumW)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .y_o      (alu_y),
    .borrow_o (alu_borrow)
  );

  // entries never written since reset count as zero
  assign old_val  = valid_q[idx_q] ? ram_rdata : '0;
  assign trial    = {rem_q, quo_q[QuoW-1]};
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    alu_op      = rmf_pkg::ALU_ADD;
    alu_a       = sum_q;
    alu_b       = SumW'(sample_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        // ram read of the oldest entry is issued at the transfer edge
        if (in_valid_i) begin
          sample_d = in_data_i.sample;
          if (in_data_i.action) begin
            idx_d   = '0;
            sum_d   = '0;
            state_d = ST_PRIME;
          end else begin
            state_d = ST_SUB;
          end
        end
      end
      ST_SUB: begin
        alu_op         = rmf_pkg::ALU_SUB;
        alu_b          = SumW'(old_val);
        sum_d          = alu_y;
        ram_we         = 1'b1;
        valid_d[idx_q] = 1'b1;
        state_d        = ST_ADD;
      end
      ST_ADD: begin
        sum_d   = alu_y;
        idx_d   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
        cnt_d   = (cnt_q < FullCnt) ? cnt_q + 1'b1 : cnt_q;
        quo_d   = {alu_y, {FracW{1'b0}}};
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_PRIME: begin
        // one entry per cycle, sum built up by repeated add
        ram_we         = 1'b1;
        valid_d[idx_q] = 1'b1;
        sum_d          = alu_y;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          cnt_d   = FullCnt;
          quo_d   = {alu_y, {FracW{1'b0}}};
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        alu_op = rmf_pkg::ALU_SUB;
        alu_a  = SumW'(trial);
        alu_b  = SumW'(cnt_q);
        rem_d  = alu_borrow ? trial[CntW-1:0] : alu_y[CntW-1:0];
        quo_d  = {quo_q[QuoW-2:0], !alu_borrow};
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.average_q8 = quo_q[AvgW-1:0];
          out_d.fill_count = FillW'(cnt_q);
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    out_q    <= out_d;
  end

  `RMF_ASSERT(a_idx_range, idx_q <= LastIdx, "ring index beyond window")
  `RMF_ASSERT(a_sum_range, sum_q <= SumLimit, "running sum above window maximum")
  `RMF_ASSERT(a_cnt_nonzero, out_valid_q |-> (cnt_q != '0), "result with empty window")
  `RMF_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && !in_stall_o, in_stall_o, "not busy after transfer")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the running mean filter unit
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FILTER_LEN = 10;
  localparam int unsigned SUM_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned STUCK_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned IDLE_PCT     = 17;
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_PRIME  = 1'b1;

  typedef struct {
    rmf_pkg::rmf_in_t item;
    bit               drain;
  } pending_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  rmf_pkg::rmf_in_t  in_data = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rmf_pkg::rmf_out_t out_data;

  pending_t          pending_q[$];
  rmf_pkg::rmf_out_t mean_q[$];
  rmf_pkg::rmf_out_t want;
  int unsigned in_xfers;
  int unsigned err_cnt;
  int unsigned stuck_cycles;

  // local copy of the filter state
  logic [rmf_pkg::SAMPLE_W-1:0] hist_mem [FILTER_LEN];
  logic [SUM_BITS-1:0]          run_sum;
  logic [3:0]                   ring_pos;
  logic [rmf_pkg::FILL_W-1:0]   fill_cnt;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  running_mean_filter_unit #(
    .WINDOW(FILTER_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  function automatic rmf_pkg::rmf_out_t filter_mean(input rmf_pkg::rmf_in_t item);
    rmf_pkg::rmf_out_t         res;
    logic [rmf_pkg::AVG_W+3:0] scaled;
    if (item.action == ACT_PRIME) begin
      for (int i = 0; i < FILTER_LEN; i++) hist_mem[i] = item.sample;
      run_sum  = SUM_BITS'(item.sample) * SUM_BITS'(FILTER_LEN);
      fill_cnt = rmf_pkg::FILL_W'(FILTER_LEN);
      ring_pos = '0;
    end else begin
      run_sum = run_sum - SUM_BITS'(hist_mem[ring_pos]) + SUM_BITS'(item.sample);
      hist_mem[ring_pos] = item.sample;
      ring_pos = (ring_pos == FILTER_LEN - 1) ? 4'd0 : ring_pos + 4'd1;
      if (fill_cnt < FILTER_LEN) fill_cnt = fill_cnt + 1'b1;
    end
    scaled = {run_sum, 8'd0};
    res.average_q8 = rmf_pkg::AVG_W'(scaled / fill_cnt);
    res.fill_count = fill_cnt;
    return res;
  endfunction

  function automatic bit idle_draw();
    // no idle gaps or output stalls in the middle of the run
    if (in_xfers >= 250 && in_xfers < 420) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  function automatic logic [rmf_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return rmf_pkg::SAMPLE_W'($urandom_range(0, 15));
      3:       return rmf_pkg::SAMPLE_W'(4095 - $urandom_range(0, 15));
      default: return rmf_pkg::SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic add_item(input logic act, input logic [rmf_pkg::SAMPLE_W-1:0] val,
                          input bit drain);
    pending_t p;
    p.item.action = act;
    p.item.sample = val;
    p.drain       = drain;
    pending_q.push_back(p);
  endtask

  // driver: predicts on each input transfer, then presents the next item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        mean_q.push_back(filter_mean(in_data));
        in_xfers++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && !(pending_q[0].drain && mean_q.size() != 0)
            && !idle_draw()) begin
          in_valid <= 1'b1;
          in_data  <= pending_q[0].item;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each output transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          $error("result with nothing pending: average_q8 %0d fill_count %0d",
                 out_data.average_q8, out_data.fill_count);
          err_cnt++;
        end else begin
          want = mean_q.pop_front();
          if (out_data.average_q8 !== want.average_q8) begin
            $error("average_q8 mismatch: expected %0d, got %0d",
                   want.average_q8, out_data.average_q8);
            err_cnt++;
          end
          if (out_data.fill_count !== want.fill_count) begin
            $error("fill_count mismatch: expected %0d, got %0d",
                   want.fill_count, out_data.fill_count);
            err_cnt++;
          end
        end
      end
      out_stall <= idle_draw();
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic act;
    for (int i = 0; i < FILTER_LEN; i++) hist_mem[i] = '0;
    run_sum  = '0;
    ring_pos = '0;
    fill_cnt = '0;
    in_xfers = 0;
    err_cnt  = 0;

    // warm-up, prime during warm-up, full-scale window, wrap and priming extremes
    add_item(ACT_FILTER, 12'h800, 1'b0);
    add_item(ACT_FILTER, 12'h7FF, 1'b0);
    add_item(ACT_PRIME, 12'hABC, 1'b0);
    add_item(ACT_FILTER, 12'h000, 1'b0);
    for (int i = 0; i < FILTER_LEN + 1; i++) add_item(ACT_FILTER, 12'hFFF, 1'b0);
    add_item(ACT_PRIME, 12'hFFF, 1'b0);
    add_item(ACT_PRIME, 12'h000, 1'b0);
    add_item(ACT_FILTER, 12'h001, 1'b0);
    add_item(ACT_FILTER, 12'h555, 1'b0);
    add_item(ACT_FILTER, 12'hAAA, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      act = ($urandom_range(0, 11) == 0) ? ACT_PRIME : ACT_FILTER;
      add_item(act, pick_sample(), (n % 200) == 199);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_q.size() != 0 || in_valid || mean_q.size() != 0)
           && stuck_cycles < STUCK_LIMIT) @(negedge clk_i);

    if (stuck_cycles >= STUCK_LIMIT) begin
      $error("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("Mismatches found");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mean_q.size() != 0) begin
        $error("%0d results never arrived", mean_q.size());
        err_cnt++;
      end
      if (err_cnt == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rmf_pkg.sv
rtl/rmf_ram.sv
rtl/rmf_alu.sv
rtl/running_mean_filter_unit.sv
tb/tb_top.sv
